// ===== rtl/core/sftc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sftc_pkg;

    localparam int ACC_W  = 52;
    localparam int OPD_W  = 33;
    localparam int PROD_W = 66;

    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_SETREF = 2'd2;
    localparam logic [1:0] REQ_STOP   = 2'd3;

    localparam logic [2:0] MUL_T0  = 3'd0;
    localparam logic [2:0] MUL_T1  = 3'd1;
    localparam logic [2:0] MUL_T2  = 3'd2;
    localparam logic [2:0] MUL_T3  = 3'd3;
    localparam logic [2:0] MUL_DT  = 3'd4;
    localparam logic [2:0] MUL_INC = 3'd5;

    localparam logic [2:0] CFG_GAIN_MP   = 3'd0;
    localparam logic [2:0] CFG_GAIN_LP   = 3'd1;
    localparam logic [2:0] CFG_GAIN_MV   = 3'd2;
    localparam logic [2:0] CFG_GAIN_LV   = 3'd3;
    localparam logic [2:0] CFG_INT_GAIN  = 3'd4;
    localparam logic [2:0] CFG_MAX_TRQ   = 3'd5;
    localparam logic [2:0] CFG_DIFF_MODE = 3'd6;

    localparam logic [1:0] LIM_NONE = 2'd0;
    localparam logic [1:0] LIM_HIGH = 2'd1;
    localparam logic [1:0] LIM_LOW  = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       acc_add;
        logic       start_fin;
        logic       cmd_fin;
        logic       int_fin;
        logic       res_load;
    } dp_cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31]))
            r = v[31:0];
        else if (v[ACC_W-1])
            r = 32'sh8000_0000;
        else
            r = 32'sh7fff_ffff;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sftc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sftc_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_req,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sftc_pkg::dp_cmd_t      cmd
);
    import sftc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FB     = 3'd1;
    localparam logic [2:0] S_FB_END = 3'd2;
    localparam logic [2:0] S_START  = 3'd3;
    localparam logic [2:0] S_CMD    = 3'd4;
    localparam logic [2:0] S_INC    = 3'd5;
    localparam logic [2:0] S_INT    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] req_reg, req_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req_next   = req_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    req_next    = in_req;
                    cnt_next    = 2'd0;
                    if (in_req == REQ_START || in_req == REQ_UPDATE)
                        state_next = S_FB;
                    else
                        state_next = S_DONE;
                end
            end
            S_FB:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = {1'b0, cnt_reg};
                cmd.acc_add = (cnt_reg != 2'd0);
                cnt_next    = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = S_FB_END;
            end
            S_FB_END:
            begin
                cmd.acc_add = 1'b1;
                state_next  = (req_reg == REQ_START) ? S_START : S_CMD;
            end
            S_START:
            begin
                cmd.start_fin = 1'b1;
                state_next    = S_DONE;
            end
            S_CMD:
            begin
                cmd.cmd_fin = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DT;
                state_next  = S_INC;
            end
            S_INC:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INC;
                state_next  = S_INT;
            end
            S_INT:
            begin
                cmd.int_fin = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 2'd0;
            req_reg       <= REQ_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            req_reg       <= req_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");

    // one item in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while busy");

    // feedback sum is finished only for start and update
    a_fb_req: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_fin || cmd.cmd_fin) |-> $past(cmd.acc_add))
        else $error("feedback sum incomplete");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped");

endmodule

`default_nettype wire

// ===== rtl/core/sftc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sftc_datapath
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  sftc_pkg::dp_cmd_t        cmd,
    input  wire logic                cfg_write,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,
    input  wire logic [1:0]          req_type,
    input  wire logic signed [31:0]  motor_pos,
    input  wire logic signed [31:0]  link_pos,
    input  wire logic signed [31:0]  motor_vel,
    input  wire logic signed [31:0]  link_vel,
    input  wire logic signed [31:0]  motor_effort,
    input  wire logic [31:0]         step_time,
    input  wire logic signed [31:0]  new_ref_pos,
    input  wire logic signed [31:0]  new_ref_vel,
    input  wire logic signed [31:0]  new_feedforward,
    output logic signed [31:0]       torque_command,
    output logic                     command_valid,
    output logic [1:0]               limit_state
);
    import sftc_pkg::*;

    // configuration
    logic signed [31:0] gmp_reg, glp_reg, gmv_reg, glv_reg;
    logic [30:0]        igain_reg, max_reg;
    logic               diff_reg;

    // controller state
    logic signed [31:0] hrp_reg, hrv_reg, ff_reg, integ_reg, mpt_reg, mvt_reg;

    // latched item
    logic [1:0]         req_reg;
    logic signed [31:0] mp_reg, lp_reg, mv_reg, lv_reg, eff_reg;
    logic [31:0]        dt_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [31:0]       cmd_reg;
    logic [1:0]               limit_reg;
    logic                     do_int_reg;

    logic signed [31:0] torque_reg;
    logic               cv_reg;
    logic [1:0]         lim_out_reg;

    logic signed [31:0]       r_mp, r_lp, r_mv, r_lv;
    logic signed [OPD_W-1:0]  opa, opb, err;
    logic signed [PROD_W-1:0] mul_out;
    logic signed [ACC_W-1:0]  term, cmd_sum, max_w;
    logic [30:0]              dtk;
    logic                     is_start;

    assign is_start = (req_reg == REQ_START);
    assign r_mp = !diff_reg ? 32'sd0 : (is_start ? mpt_reg : hrp_reg);
    assign r_lp = diff_reg ? hrp_reg : 32'sd0;
    assign r_mv = !diff_reg ? 32'sd0 : (is_start ? mvt_reg : hrv_reg);
    assign r_lv = diff_reg ? hrv_reg : 32'sd0;

    assign err = OPD_W'(hrp_reg) - OPD_W'(lp_reg);
    assign dtk = prod_reg[62:32];

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_T0:
            begin
                opa = OPD_W'(gmp_reg);
                opb = OPD_W'(r_mp) - OPD_W'(mp_reg);
            end
            MUL_T1:
            begin
                opa = OPD_W'(glp_reg);
                opb = OPD_W'(r_lp) - OPD_W'(lp_reg);
            end
            MUL_T2:
            begin
                opa = OPD_W'(gmv_reg);
                opb = OPD_W'(r_mv) - OPD_W'(mv_reg);
            end
            MUL_T3:
            begin
                opa = OPD_W'(glv_reg);
                opb = OPD_W'(r_lv) - OPD_W'(lv_reg);
            end
            MUL_DT:
            begin
                opa = $signed({1'b0, dt_reg});
                opb = $signed({2'b00, igain_reg});
            end
            MUL_INC:
            begin
                opa = $signed({2'b00, dtk});
                opb = err;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign mul_out = opa * opb;
    assign term    = ACC_W'(prod_reg >>> 16);
    assign cmd_sum = acc_reg + ACC_W'(integ_reg) + ACC_W'(ff_reg);
    assign max_w   = $signed({{(ACC_W-31){1'b0}}, max_reg});

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg <= req_type;
            mp_reg  <= motor_pos;
            lp_reg  <= link_pos;
            mv_reg  <= motor_vel;
            lv_reg  <= link_vel;
            eff_reg <= motor_effort;
            dt_reg  <= step_time;
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + term;
        end
        if (cmd.mul_en)
            prod_reg <= mul_out;
        if (cmd.cmd_fin)
        begin
            if (cmd_sum > max_w)
            begin
                cmd_reg    <= max_w[31:0];
                limit_reg  <= LIM_HIGH;
                do_int_reg <= err[OPD_W-1];
            end
            else if (cmd_sum < -max_w)
            begin
                cmd_reg    <= -max_w[31:0];
                limit_reg  <= LIM_LOW;
                do_int_reg <= !err[OPD_W-1] && (err != '0);
            end
            else
            begin
                cmd_reg    <= cmd_sum[31:0];
                limit_reg  <= LIM_NONE;
                do_int_reg <= 1'b1;
            end
        end
        if (cmd.res_load)
        begin
            case (req_reg)
                REQ_UPDATE:
                begin
                    torque_reg  <= cmd_reg;
                    cv_reg      <= 1'b1;
                    lim_out_reg <= limit_reg;
                end
                REQ_STOP:
                begin
                    torque_reg  <= 32'sd0;
                    cv_reg      <= 1'b1;
                    lim_out_reg <= LIM_NONE;
                end
                default:
                begin
                    torque_reg  <= 32'sd0;
                    cv_reg      <= 1'b0;
                    lim_out_reg <= LIM_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gmp_reg   <= '0;
            glp_reg   <= '0;
            gmv_reg   <= '0;
            glv_reg   <= '0;
            igain_reg <= '0;
            max_reg   <= '0;
            diff_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_GAIN_MP:   gmp_reg   <= cfg_data;
                CFG_GAIN_LP:   glp_reg   <= cfg_data;
                CFG_GAIN_MV:   gmv_reg   <= cfg_data;
                CFG_GAIN_LV:   glv_reg   <= cfg_data;
                CFG_INT_GAIN:  igain_reg <= cfg_data[30:0];
                CFG_MAX_TRQ:   max_reg   <= cfg_data[30:0];
                CFG_DIFF_MODE: diff_reg  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hrp_reg   <= '0;
            hrv_reg   <= '0;
            ff_reg    <= '0;
            integ_reg <= '0;
            mpt_reg   <= '0;
            mvt_reg   <= '0;
        end
        else
        begin
            if (cmd.load_in && req_type == REQ_START)
            begin
                hrp_reg <= link_pos;
                hrv_reg <= '0;
                ff_reg  <= '0;
            end
            else if (cmd.load_in && req_type == REQ_SETREF)
            begin
                hrp_reg <= new_ref_pos;
                hrv_reg <= new_ref_vel;
                ff_reg  <= new_feedforward;
            end
            if (cmd.start_fin)
                integ_reg <= sat32(ACC_W'(eff_reg) - acc_reg);
            else if (cmd.int_fin && do_int_reg)
                integ_reg <= sat32(ACC_W'(integ_reg) + term);
            if (cmd.cmd_fin && diff_reg)
            begin
                mpt_reg <= hrp_reg;
                mvt_reg <= hrv_reg;
            end
        end
    end

    assign torque_command = torque_reg;
    assign command_valid  = cv_reg;
    assign limit_state    = lim_out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/state_feedback_integral_torque_control.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_ready    req_type, measurements, step_time, references
// out       out_valid / out_ready  torque_command, command_valid, limit_state
// cfg       cfg_write              cfg_index, cfg_data (no wait, no read-back)
//
// One item at a time through a single shared 33x33 multiplier.
// Update: four feedback products, clamp, then two products for the integral
// step; start: the four feedback products; set reference and stop: none.
// Reset clears gains, references and integral; no clearing pass.
// A result held by out_ready low stalls only the final step; input waits.
`timescale 1ns / 1ps
`default_nettype none

module state_feedback_integral_torque_control
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          req_type,
    input  wire logic signed [31:0]  motor_pos,
    input  wire logic signed [31:0]  link_pos,
    input  wire logic signed [31:0]  motor_vel,
    input  wire logic signed [31:0]  link_vel,
    input  wire logic signed [31:0]  motor_effort,
    input  wire logic [31:0]         step_time,
    input  wire logic signed [31:0]  new_ref_pos,
    input  wire logic signed [31:0]  new_ref_vel,
    input  wire logic signed [31:0]  new_feedforward,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [31:0]       torque_command,
    output logic                     command_valid,
    output logic [1:0]               limit_state
);
    import sftc_pkg::*;

    dp_cmd_t cmd;

    sftc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sftc_datapath u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_type        (req_type),
        .motor_pos       (motor_pos),
        .link_pos        (link_pos),
        .motor_vel       (motor_vel),
        .link_vel        (link_vel),
        .motor_effort    (motor_effort),
        .step_time       (step_time),
        .new_ref_pos     (new_ref_pos),
        .new_ref_vel     (new_ref_vel),
        .new_feedforward (new_feedforward),
        .torque_command  (torque_command),
        .command_valid   (command_valid),
        .limit_state     (limit_state)
    );

endmodule

`default_nettype wire
